FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the pose lookup RTL.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define TPL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence at the next clock edge.
`define TPL_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tpl_pkg.sv
// Shared types, constants and helpers for the timestamp pose lookup.
// No dependencies.
package tpl_pkg;

    localparam int TPL_TABLE_DEPTH = 1024;
    localparam int TPL_W           = 32;
    localparam int TPL_STAMP_W     = 64;
    localparam int TPL_IN_DATA_W   = 288;
    localparam int TPL_OUT_DATA_W  = 128;
    localparam int TPL_OUT_USER_W  = 3;
    localparam int TPL_TERM_W      = 35;
    localparam int TPL_SUM_W       = 37;

    localparam logic TPL_KIND_LOAD  = 1'b0;
    localparam logic TPL_KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                          kind;
        logic [TPL_STAMP_W-1:0]        stamp;
        logic [3:0][TPL_W-1:0]         quat;   // w, x, y, z at index 0..3
        logic [2:0][TPL_W-1:0]         pos;    // x, y, z at index 0..2
    } t_item;

    function automatic logic [TPL_W-1:0] sat32(input logic signed [TPL_SUM_W-1:0] v);
        logic [TPL_W-1:0] res;
        if (v > TPL_SUM_W'(signed'(32'h7FFF_FFFF))) begin
            res = 32'h7FFF_FFFF;
        end else if (v < TPL_SUM_W'(signed'(32'h8000_0000))) begin
            res = 32'h8000_0000;
        end else begin
            res = v[TPL_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/timestamp_pose_lookup_top.sv
// Top level of the timestamp pose lookup: front queue and back end.
// Depends on tpl_pkg, tpl_front and tpl_back.
//
// Channel   Dir  Payload
// s_axis    in   tuser: kind; tdata: stamp, quat w..z, pos x..z (288 bits)
// m_axis    out  tuser: found, row_index; tdata: rot_col0..2, translation;
//                tlast: last
//
// A load is written to the table as the back end takes it, unless the table is
// full. A query leaves the queue, then for each table entry the cursor visits
// the back end does a registered memory read, then a compare. A hit then runs
// the nine products on the single 32x32 multiplier and emits the rows; a miss
// does an end-of-table read, then emits its row. A stalled output register holds
// the back end on its row. Reset is synchronous, active low, and empties the
// table; memories are not cleared. The two-entry queue keeps taking items, until
// it is full, while the output register is stalled.
module timestamp_pose_lookup_top #(
    parameter int TABLE_DEPTH = tpl_pkg::TPL_TABLE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // stamp[63:0], quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z
    input  logic [tpl_pkg::TPL_IN_DATA_W-1:0]    s_axis_tdata,
    // kind[0]
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // rot_col0[31:0], rot_col1, rot_col2, translation
    output logic [tpl_pkg::TPL_OUT_DATA_W-1:0]   m_axis_tdata,
    // found[0], row_index[2:1]
    output logic [tpl_pkg::TPL_OUT_USER_W-1:0]   m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import tpl_pkg::*;

    t_item w_in_item, w_q_item;
    logic  w_q_valid, w_pop;

    // Unpack the stream word into item fields.
    always_comb begin
        w_in_item.kind  = s_axis_tuser;
        w_in_item.stamp = s_axis_tdata[63:0];
        for (int k = 0; k < 4; k++) begin
            w_in_item.quat[k] = s_axis_tdata[64 + 32*k +: 32];
        end
        for (int k = 0; k < 3; k++) begin
            w_in_item.pos[k] = s_axis_tdata[192 + 32*k +: 32];
        end
    end

    tpl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    tpl_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );
endmodule

FILE: rtl/core/tpl_front.sv
// Front end: accepts stream items and holds them in a two-entry queue.
// Depends on tpl_pkg.
module tpl_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  tpl_pkg::t_item                i_item,
    output logic                          o_valid,
    output tpl_pkg::t_item                o_item,
    input  logic                          i_pop
);
    import tpl_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rptr];
    assign w_push  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end
endmodule

FILE: rtl/core/tpl_back.sv
// Back end: pose table memories, forward cursor search, quaternion to
// rotation conversion on one shared multiplier, and the output register.
// Depends on tpl_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tpl_back #(
    parameter int TABLE_DEPTH = tpl_pkg::TPL_TABLE_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  tpl_pkg::t_item                        i_item,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [tpl_pkg::TPL_OUT_DATA_W-1:0]    o_data,
    output logic [tpl_pkg::TPL_OUT_USER_W-1:0]    o_user,
    output logic                                  o_last
);
    import tpl_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = AW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ROW  = 3'd4;
    localparam logic [2:0] S_FAIL = 3'd5;

    logic [2:0]                  r_state, n_state;
    logic [CW-1:0]               r_count, r_idx, r_cursor;
    logic [TPL_STAMP_W-1:0]      r_qtime;
    logic [3:0]                  r_mcnt;
    logic [1:0]                  r_row;

    logic [TPL_STAMP_W-1:0]      r_time_mem [TABLE_DEPTH];
    logic [4*TPL_W-1:0]          r_quat_mem [TABLE_DEPTH];
    logic [3*TPL_W-1:0]          r_pos_mem  [TABLE_DEPTH];
    logic [TPL_STAMP_W-1:0]      r_t_lo, r_t_hi;
    logic [3:0][TPL_W-1:0]       r_quat_q;
    logic [2:0][TPL_W-1:0]       r_pos_q;

    logic signed [2*TPL_W-1:0]   r_prod;
    logic signed [TPL_TERM_W-1:0] r_term [9];

    logic                        r_out_valid, r_out_found, r_out_last;
    logic [1:0]                  r_out_row;
    logic [3:0][TPL_W-1:0]       r_out_data;

    logic                        w_take, w_we, w_slot_free, w_hit, w_end;
    logic [AW-1:0]               w_rd_a, w_rd_b;
    logic signed [TPL_W-1:0]     w_ma, w_mb;
    logic signed [TPL_SUM_W-1:0] w_r [9];
    logic signed [TPL_SUM_W-1:0] w_one;

    assign w_take      = (r_state == S_IDLE) && i_valid;
    assign o_pop       = w_take;
    assign w_we        = w_take && (i_item.kind == TPL_KIND_LOAD) &&
                         (r_count < CW'(TABLE_DEPTH));
    assign w_rd_a      = r_idx[AW-1:0];
    assign w_rd_b      = AW'(r_idx + CW'(1));
    assign w_slot_free = !r_out_valid || i_ready;
    assign w_end       = (r_idx + CW'(1)) >= r_count;
    assign w_hit       = (r_t_lo <= r_qtime) && (r_t_hi >= r_qtime);

    // Table memories: one write port, registered reads at the cursor pair.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_time_mem[r_count[AW-1:0]] <= i_item.stamp;
            r_quat_mem[r_count[AW-1:0]] <= i_item.quat;
            r_pos_mem[r_count[AW-1:0]]  <= i_item.pos;
        end
        r_t_lo   <= r_time_mem[w_rd_a];
        r_t_hi   <= r_time_mem[w_rd_b];
        r_quat_q <= r_quat_mem[w_rd_a];
        r_pos_q  <= r_pos_mem[w_rd_a];
    end

    // Shared multiplier: xx, yy, zz, xy, xz, yz, wx, wy, wz in that order.
    always_comb begin
        case (r_mcnt)
            4'd0:    begin w_ma = r_quat_q[1]; w_mb = r_quat_q[1]; end
            4'd1:    begin w_ma = r_quat_q[2]; w_mb = r_quat_q[2]; end
            4'd2:    begin w_ma = r_quat_q[3]; w_mb = r_quat_q[3]; end
            4'd3:    begin w_ma = r_quat_q[1]; w_mb = r_quat_q[2]; end
            4'd4:    begin w_ma = r_quat_q[1]; w_mb = r_quat_q[3]; end
            4'd5:    begin w_ma = r_quat_q[2]; w_mb = r_quat_q[3]; end
            4'd6:    begin w_ma = r_quat_q[0]; w_mb = r_quat_q[1]; end
            4'd7:    begin w_ma = r_quat_q[0]; w_mb = r_quat_q[2]; end
            default: begin w_ma = r_quat_q[0]; w_mb = r_quat_q[3]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod <= w_ma * w_mb;
            if (r_mcnt != 4'd0) begin
                // floor of 2*a*b in Q2.30 is an arithmetic shift by 29
                r_term[r_mcnt - 4'd1] <= r_prod[2*TPL_W-1:29];
            end
        end
    end

    // Rotation elements from the terms, before saturation.
    always_comb begin
        w_one = TPL_SUM_W'(1) <<< 30;
        w_r[0] = w_one - (TPL_SUM_W'(r_term[1]) + TPL_SUM_W'(r_term[2]));
        w_r[1] = TPL_SUM_W'(r_term[3]) - TPL_SUM_W'(r_term[8]);
        w_r[2] = TPL_SUM_W'(r_term[4]) + TPL_SUM_W'(r_term[7]);
        w_r[3] = TPL_SUM_W'(r_term[3]) + TPL_SUM_W'(r_term[8]);
        w_r[4] = w_one - (TPL_SUM_W'(r_term[0]) + TPL_SUM_W'(r_term[2]));
        w_r[5] = TPL_SUM_W'(r_term[5]) - TPL_SUM_W'(r_term[6]);
        w_r[6] = TPL_SUM_W'(r_term[4]) - TPL_SUM_W'(r_term[7]);
        w_r[7] = TPL_SUM_W'(r_term[5]) + TPL_SUM_W'(r_term[6]);
        w_r[8] = w_one - (TPL_SUM_W'(r_term[0]) + TPL_SUM_W'(r_term[1]));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_take && i_item.kind == TPL_KIND_QUERY) n_state = S_RD;
            S_RD:   n_state = w_end ? S_FAIL : S_CMP;
            S_CMP:  n_state = w_hit ? S_MUL : S_RD;
            S_MUL:  if (r_mcnt == 4'd9) n_state = S_ROW;
            S_ROW:  if (w_slot_free && r_row == 2'd2) n_state = S_IDLE;
            S_FAIL: if (w_slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_idx       <= '0;
            r_mcnt      <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_we) r_count <= r_count + CW'(1);
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_idx   <= r_cursor;
                    r_qtime <= i_item.stamp;
                    r_mcnt  <= '0;
                    r_row   <= '0;
                end
                S_CMP: begin
                    if (w_hit) r_cursor <= r_idx;
                    else       r_idx    <= r_idx + CW'(1);
                end
                S_MUL: r_mcnt <= r_mcnt + 4'd1;
                S_ROW: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= 1'b1;
                        r_out_row   <= r_row;
                        r_out_last  <= (r_row == 2'd2);
                        r_out_data[0] <= sat32(w_r[3*r_row]);
                        r_out_data[1] <= sat32(w_r[3*r_row + 1]);
                        r_out_data[2] <= sat32(w_r[3*r_row + 2]);
                        r_out_data[3] <= r_pos_q[r_row];
                        r_row <= r_row + 2'd1;
                    end
                end
                S_FAIL: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= 1'b0;
                        r_out_row   <= 2'd0;
                        r_out_last  <= 1'b1;
                        r_out_data  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_user  = {r_out_row, r_out_found};
    assign o_last  = r_out_last;

    `TPL_ASSERT(a_count_cap, r_count <= CW'(TABLE_DEPTH), "entry count past table depth")
    `TPL_ASSERT(a_cursor_ok, (r_cursor == '0) || ((r_cursor + CW'(1)) < r_count),
                "cursor outside the loaded bracket range")
    `TPL_ASSERT_NEXT(a_hit_mul, (r_state == S_CMP) && w_hit, r_state == S_MUL,
                     "bracket hit did not start the conversion")
endmodule

FILE: dv/testbench.sv
// Self-checking bench for timestamp_pose_lookup_top: table loads, time queries, row checks.
// Depends on tpl_pkg and the RTL below timestamp_pose_lookup_top; reads no files.
`timescale 1ns / 1ps

module testbench;
    import tpl_pkg::*;

    // Small table so that the full-table case is reached in a short run
    localparam int DEPTH    = 64;
    localparam int N_RANDOM = 60;
    localparam int LIMIT    = 400000;
    localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {CHK_MODEL, CHK_MISS, CHK_IDENT} t_chk;

    typedef struct {
        logic        found;
        logic [1:0]  row;
        logic [31:0] c0, c1, c2, tr;
        logic        last;
    } t_pose_row;

    typedef struct {
        logic        kind;
        logic [63:0] stamp;
        logic [31:0] q[4];
        logic [31:0] p[3];
        t_chk        how;
    } t_stim;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [TPL_IN_DATA_W-1:0] s_axis_tdata = '0;   // stamp, quat w,x,y,z, pos x,y,z
    logic        s_axis_tuser = 1'b0;              // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [TPL_OUT_DATA_W-1:0] m_axis_tdata;       // rot_col0, rot_col1, rot_col2, translation
    logic [TPL_OUT_USER_W-1:0] m_axis_tuser;       // found[0], row_index[2:1]
    logic        m_axis_tlast;

    timestamp_pose_lookup_top #(.TABLE_DEPTH(DEPTH)) DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the pose table
    logic [63:0] shadow_time[DEPTH];
    logic [31:0] shadow_quat[DEPTH][4];
    logic [31:0] shadow_pos[DEPTH][3];
    int          shadow_count = 0;
    int          shadow_cursor = 0;
    logic [63:0] newest_stamp = 0;

    t_pose_row rows_due[$];
    int errors = 0;
    int n_rows = 0, n_hits = 0, n_misses = 0, n_loads = 0, n_dropped = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;
    longint unsigned cycles = 0;

    // 2*a*b in Q2.30, floor rounding via arithmetic shift
    function automatic longint twice_prod(logic [31:0] a, logic [31:0] b);
        longint p;
        p = longint'($signed(a)) * longint'($signed(b));
        return p >>> 29;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
        if (v < -longint'(64'sh8000_0000)) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic void store_pose(t_stim s);
        if (shadow_count < DEPTH) begin
            shadow_time[shadow_count] = s.stamp;
            for (int k = 0; k < 4; k++) shadow_quat[shadow_count][k] = s.q[k];
            for (int k = 0; k < 3; k++) shadow_pos[shadow_count][k] = s.p[k];
            shadow_count++;
            n_loads++;
        end else begin
            n_dropped++;
        end
    endfunction

    // Walk forward from the cursor; fill the transform rows, return the row count
    function automatic int lookup_pose(logic [63:0] t, output t_pose_row r[3]);
        int hit;
        longint w, x, y, z, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint unit_q, m[9];
        hit = -1;
        unit_q = longint'(1) << 30;
        for (int i = shadow_cursor; i + 1 < shadow_count; i++) begin
            if (shadow_time[i] <= t && shadow_time[i+1] >= t) begin
                hit = i;
                break;
            end
        end
        if (hit < 0) begin
            r[0] = '{1'b0, 2'd0, '0, '0, '0, '0, 1'b1};
            return 1;
        end
        shadow_cursor = hit;
        xx = twice_prod(shadow_quat[hit][1], shadow_quat[hit][1]);
        yy = twice_prod(shadow_quat[hit][2], shadow_quat[hit][2]);
        zz = twice_prod(shadow_quat[hit][3], shadow_quat[hit][3]);
        xy = twice_prod(shadow_quat[hit][1], shadow_quat[hit][2]);
        xz = twice_prod(shadow_quat[hit][1], shadow_quat[hit][3]);
        yz = twice_prod(shadow_quat[hit][2], shadow_quat[hit][3]);
        wx = twice_prod(shadow_quat[hit][0], shadow_quat[hit][1]);
        wy = twice_prod(shadow_quat[hit][0], shadow_quat[hit][2]);
        wz = twice_prod(shadow_quat[hit][0], shadow_quat[hit][3]);
        m = '{unit_q - (yy + zz), xy - wz, xz + wy,
              xy + wz, unit_q - (xx + zz), yz - wx,
              xz - wy, yz + wx, unit_q - (xx + yy)};
        for (int k = 0; k < 3; k++)
            r[k] = '{1'b1, 2'(k), clamp32(m[3*k]), clamp32(m[3*k+1]), clamp32(m[3*k+2]),
                     shadow_pos[hit][k], k == 2};
        return 3;
    endfunction

    function automatic t_stim mk(logic k, logic [63:0] s, logic [31:0] w, x, y, z,
                                 logic [31:0] px, py, pz, t_chk h);
        t_stim r;
        r.kind = k; r.stamp = s;
        r.q = '{w, x, y, z};
        r.p = '{px, py, pz};
        r.how = h;
        return r;
    endfunction

    function automatic t_stim rand_load(logic [63:0] s);
        t_stim r;
        r.kind = TPL_KIND_LOAD; r.stamp = s; r.how = CHK_MODEL;
        // Mostly unit-ish quaternions, sometimes any bit pattern
        for (int k = 0; k < 4; k++)
            r.q[k] = ($urandom_range(0, 3) == 0) ? $urandom
                     : 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
        for (int k = 0; k < 3; k++) r.p[k] = $urandom;
        return r;
    endfunction

    // Hand one item over, then update the shadow table and queue its rows
    task automatic send_item(t_stim s);
        t_pose_row r[3];
        int n;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= s.kind;
        s_axis_tdata  <= {s.p[2], s.p[1], s.p[0], s.q[3], s.q[2], s.q[1], s.q[0], s.stamp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (s.kind == TPL_KIND_LOAD) begin
            store_pose(s);
            if (s.stamp > newest_stamp) newest_stamp = s.stamp;
            return;
        end
        n = lookup_pose(s.stamp, r);
        if (n == 3) n_hits++; else n_misses++;
        // Typed rows replace the computed ones where the answer is obvious
        if (s.how == CHK_MISS)
            r[0] = '{1'b0, 2'd0, '0, '0, '0, '0, 1'b1};
        else if (s.how == CHK_IDENT)
            for (int k = 0; k < 3; k++)
                r[k] = '{1'b1, 2'(k), (k == 0) ? 32'h4000_0000 : 32'h0,
                         (k == 1) ? 32'h4000_0000 : 32'h0,
                         (k == 2) ? 32'h4000_0000 : 32'h0, s.p[k], k == 2};
        if (s.how == CHK_MISS) n = 1;
        if (s.how == CHK_IDENT) n = 3;
        for (int k = 0; k < n; k++) rows_due = {rows_due, r[k]};
    endtask

    task automatic drain_rows();
        s_axis_tvalid <= 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Result side: check against the oldest expected row, then pick the next stall
    always @(posedge i_clk) begin
        t_pose_row e;
        if (m_axis_tvalid && m_axis_tready) begin
            n_rows++;
            if (rows_due.size() == 0) begin
                $error("unexpected result row, tuser=%0h tdata=%0h", m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                e = rows_due.pop_front();
                if (m_axis_tuser[0] !== e.found) begin
                    $error("found: expected %0h actual %0h", e.found, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[2:1] !== e.row) begin
                    $error("row_index: expected %0d actual %0d", e.row, m_axis_tuser[2:1]);
                    errors++;
                end
                if (m_axis_tdata[31:0] !== e.c0) begin
                    $error("rot_col0: expected %08h actual %08h", e.c0, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[63:32] !== e.c1) begin
                    $error("rot_col1: expected %08h actual %08h", e.c1, m_axis_tdata[63:32]);
                    errors++;
                end
                if (m_axis_tdata[95:64] !== e.c2) begin
                    $error("rot_col2: expected %08h actual %08h", e.c2, m_axis_tdata[95:64]);
                    errors++;
                end
                if (m_axis_tdata[127:96] !== e.tr) begin
                    $error("translation: expected %08h actual %08h", e.tr, m_axis_tdata[127:96]);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last: expected %0h actual %0h", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    t_stim plan[$];

    initial begin
        t_stim s;
        logic [63:0] lo_t;
        int phase_len;
        // Directed table: empty table, single entry, brackets, edges, saturation
        plan = {plan, mk(TPL_KIND_QUERY, 64'd0, 0, 0, 0, 0, 0, 0, 0, CHK_MISS)};
        plan = {plan, mk(TPL_KIND_LOAD, 64'd100, 32'h4000_0000, 0, 0, 0,
                         32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, CHK_MODEL)};
        plan = {plan, mk(TPL_KIND_QUERY, 64'd100, 0, 0, 0, 0, 0, 0, 0, CHK_MISS)};
        plan = {plan, mk(TPL_KIND_LOAD, 64'd200, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, CHK_MODEL)};
        plan = {plan, mk(TPL_KIND_QUERY, 64'd100, 0, 0, 0, 0,
                         32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, CHK_IDENT)};
        plan = {plan, mk(TPL_KIND_QUERY, 64'd150, 0, 0, 0, 0,
                         32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, CHK_IDENT)};
        plan = {plan, mk(TPL_KIND_QUERY, 64'd50, 0, 0, 0, 0, 0, 0, 0, CHK_MISS)};
        plan = {plan, mk(TPL_KIND_QUERY, 64'd250, 0, 0, 0, 0, 0, 0, 0, CHK_MISS)};
        plan = {plan, mk(TPL_KIND_LOAD, 64'd200, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 2, CHK_MODEL)};
        plan = {plan, mk(TPL_KIND_LOAD, 64'd300, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h8000_0000, 3, 4, 5, CHK_MODEL)};
        plan = {plan, mk(TPL_KIND_QUERY, 64'd200, 0, 0, 0, 0,
                         32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, CHK_IDENT)};
        plan = {plan, mk(TPL_KIND_QUERY, 64'd250, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL)};
        plan = {plan, mk(TPL_KIND_QUERY, 64'd150, 0, 0, 0, 0, 0, 0, 0, CHK_MISS)};
        plan = {plan, mk(TPL_KIND_LOAD, 64'd400, 32'h0, 32'h4000_0000, 32'h0, 32'h0,
                         32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, CHK_MODEL)};
        plan = {plan, mk(TPL_KIND_QUERY, 64'd350, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL)};
        plan = {plan, mk(TPL_KIND_QUERY, 64'd400, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL)};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) send_item(plan[k]);
        // Hold off until the directed rows are all back
        drain_rows();

        // Random part in four idling phases: none, sender gaps, receiver stalls, both
        phase_len = N_RANDOM / 4;
        for (int n = 0; n < N_RANDOM; n++) begin
            case (n / phase_len)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            if ($urandom_range(0, 99) < 45 && shadow_count < DEPTH - 4) begin
                s = rand_load(newest_stamp + $urandom_range(0, 40));
            end else begin
                s = mk(TPL_KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL);
                lo_t = (shadow_count > 0) ? shadow_time[shadow_cursor] : 0;
                if ($urandom_range(0, 99) < 75)
                    s.stamp = lo_t + $urandom_range(0, int'(newest_stamp - lo_t));
                else
                    s.stamp = {$urandom, $urandom};
            end
            send_item(s);
        end
        send_idle_pct = 10; recv_stall_pct = 10;
        drain_rows();

        // Fill the table, the last entry at the top time, then overflow it
        while (shadow_count < DEPTH - 1) send_item(rand_load(newest_stamp + $urandom_range(1, 9)));
        send_item(rand_load(T_MAX));
        repeat (3) send_item(rand_load(64'd5));
        send_item(mk(TPL_KIND_QUERY, T_MAX, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL));
        send_item(mk(TPL_KIND_QUERY, 64'd0, 0, 0, 0, 0, 0, 0, 0, CHK_MISS));
        send_item(mk(TPL_KIND_QUERY, T_MAX, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL));

        drain_rows();
        repeat (100) @(posedge i_clk);

        $display("Covered %0d loads (%0d dropped on a full table), %0d hits, %0d misses,",
                 n_loads, n_dropped, n_hits, n_misses);
        $display("%0d result rows checked in %0d cycles", n_rows, cycles);
        if (errors == 0 && rows_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/tpl_pkg.sv
rtl/core/tpl_front.sv
rtl/core/tpl_back.sv
rtl/core/timestamp_pose_lookup_top.sv
dv/testbench.sv
